>>> rtl/hlfc_pkg.sv
// shared types, codes and hex helpers for the hex ascii lrc frame codec
`timescale 1ns / 1ps

package hlfc_pkg;

   // defaults for top level parameters
   localparam int MAX_PAYLOAD_DEFAULT = 255;
   localparam int QUEUE_DEPTH_DEFAULT = 4;

   // framing characters
   localparam logic [7:0] ACK_BYTE = 8'h60;
   localparam logic [7:0] ETX_CHAR = 8'h03;

   // result kinds
   localparam logic [1:0] KIND_TX_CHAR   = 2'd0;
   localparam logic [1:0] KIND_RX_BYTE   = 2'd1;
   localparam logic [1:0] KIND_RX_STATUS = 2'd2;

   // receive frame status codes
   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_PROTOCOL = 2'd1;
   localparam logic [1:0] STATUS_CHECKSUM = 2'd2;
   localparam logic [1:0] STATUS_NO_ACK   = 2'd3;

   // sequence slots of a transmit job
   localparam logic [3:0] SLOT_HEADER = 4'd0;
   localparam logic [3:0] SLOT_DATA   = 4'd4;
   localparam logic [3:0] SLOT_DATA_LO = 4'd5;
   localparam logic [3:0] SLOT_ETX    = 4'd8;

   // one unit of work handed from front to back
   typedef struct packed {
      logic [1:0] kind;
      logic       hdr;
      logic       eop;
      logic [7:0] len_byte;
      logic [7:0] data;
      logic [7:0] lrc;
      logic [7:0] position;
      logic [1:0] status;
      logic [7:0] reply_len;
   } job_type;

   // decoded hex character: valid flag and nibble
   typedef struct packed {
      logic       valid;
      logic [3:0] nib;
   } hex_val_type;

   function automatic logic [7:0] hex_char(input logic [3:0] v, input logic lower);
      logic [7:0] c;
      if (v < 4'd10) begin
         c = 8'h30 + {4'd0, v};
      end else if (lower) begin
         c = 8'h61 + {4'd0, v} - 8'd10;
      end else begin
         c = 8'h41 + {4'd0, v} - 8'd10;
      end
      return c;
   endfunction

   function automatic hex_val_type hex_value(input logic [7:0] c);
      hex_val_type r;
      r.valid = 1'b1;
      r.nib   = 4'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         r.nib = c[3:0];
      end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
         r.nib = c[3:0] + 4'd9;
      end else begin
         r.valid = 1'b0;
      end
      return r;
   endfunction

endpackage

>>> rtl/hlfc_front.sv
// front end: frame state, receive decoding and job building
`timescale 1ns / 1ps

module hlfc_front #(
   parameter int MAX_PAYLOAD = hlfc_pkg::MAX_PAYLOAD_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  logic              func,
   input  logic [7:0]        data_byte,
   input  logic [7:0]        msg_len,
   input  logic              end_of_payload,
   input  logic [7:0]        reply_limit,
   output logic              job_valid,
   output hlfc_pkg::job_type job
);

   logic       tx_in_frame_ff, tx_in_frame_in;
   logic [7:0] tx_lrc_ff, tx_lrc_in;
   logic [7:0] rx_lrc_ff, rx_lrc_in;
   logic       rx_half_pending_ff, rx_half_pending_in;
   logic [3:0] rx_high_nibble_ff, rx_high_nibble_in;
   logic [8:0] rx_byte_count_ff, rx_byte_count_in;
   logic [7:0] rx_first_byte_ff, rx_first_byte_in;
   logic [7:0] rx_length_byte_ff, rx_length_byte_in;
   logic       rx_bad_char_ff, rx_bad_char_in;

   hlfc_pkg::hex_val_type hv;
   logic [7:0] rx_byte;
   logic [8:0] pos9;
   logic [8:0] cnt_m3;
   logic [8:0] rl9;
   logic [7:0] tx_base;
   logic [7:0] tx_new_lrc;

   always_comb begin
      hv         = hlfc_pkg::hex_value(data_byte);
      rx_byte    = {rx_high_nibble_ff, hv.nib};
      pos9       = rx_byte_count_ff - 9'd2;
      cnt_m3     = rx_byte_count_ff - 9'd3;
      tx_base    = tx_in_frame_ff ? tx_lrc_ff : (hlfc_pkg::ACK_BYTE ^ msg_len);
      tx_new_lrc = tx_base ^ data_byte;

      rl9 = (cnt_m3 < {1'b0, reply_limit}) ? cnt_m3 : {1'b0, reply_limit};
      if (rl9 > 9'(MAX_PAYLOAD)) begin
         rl9 = 9'(MAX_PAYLOAD);
      end

      tx_in_frame_in     = tx_in_frame_ff;
      tx_lrc_in          = tx_lrc_ff;
      rx_lrc_in          = rx_lrc_ff;
      rx_half_pending_in = rx_half_pending_ff;
      rx_high_nibble_in  = rx_high_nibble_ff;
      rx_byte_count_in   = rx_byte_count_ff;
      rx_first_byte_in   = rx_first_byte_ff;
      rx_length_byte_in  = rx_length_byte_ff;
      rx_bad_char_in     = rx_bad_char_ff;

      job_valid     = 1'b0;
      job.kind      = hlfc_pkg::KIND_TX_CHAR;
      job.hdr       = !tx_in_frame_ff;
      job.eop       = end_of_payload;
      job.len_byte  = msg_len;
      job.data      = data_byte;
      job.lrc       = tx_new_lrc;
      job.position  = 8'd0;
      job.status    = hlfc_pkg::STATUS_OK;
      job.reply_len = 8'd0;

      if (accept) begin
         if (!func) begin
            job_valid      = 1'b1;
            tx_in_frame_in = !end_of_payload;
            tx_lrc_in      = end_of_payload ? 8'd0 : tx_new_lrc;
         end else if (data_byte == hlfc_pkg::ETX_CHAR) begin
            job_valid = 1'b1;
            job.kind  = hlfc_pkg::KIND_RX_STATUS;
            if (rx_half_pending_ff || rx_bad_char_ff) begin
               job.status = hlfc_pkg::STATUS_PROTOCOL;
            end else if (rx_byte_count_ff < 9'd3) begin
               job.status = hlfc_pkg::STATUS_PROTOCOL;
            end else if (rx_lrc_ff != 8'd0) begin
               job.status = hlfc_pkg::STATUS_CHECKSUM;
            end else if (rx_first_byte_ff != hlfc_pkg::ACK_BYTE) begin
               job.status = hlfc_pkg::STATUS_NO_ACK;
            end else if ({1'b0, rx_length_byte_ff} != cnt_m3) begin
               job.status = hlfc_pkg::STATUS_PROTOCOL;
            end else begin
               job.reply_len = rl9[7:0];
            end
            rx_lrc_in          = 8'd0;
            rx_half_pending_in = 1'b0;
            rx_high_nibble_in  = 4'd0;
            rx_byte_count_in   = 9'd0;
            rx_first_byte_in   = 8'd0;
            rx_length_byte_in  = 8'd0;
            rx_bad_char_in     = 1'b0;
         end else begin
            if (!hv.valid) begin
               rx_bad_char_in = 1'b1;
            end
            if (!rx_half_pending_ff) begin
               rx_high_nibble_in  = hv.nib;
               rx_half_pending_in = 1'b1;
            end else begin
               rx_half_pending_in = 1'b0;
               rx_high_nibble_in  = 4'd0;
               rx_lrc_in          = rx_lrc_ff ^ rx_byte;
               if (rx_byte_count_ff == 9'd0) begin
                  rx_first_byte_in = rx_byte;
               end else if (rx_byte_count_ff == 9'd1) begin
                  rx_length_byte_in = rx_byte;
               end else if (pos9 < {1'b0, reply_limit} && pos9 < 9'(MAX_PAYLOAD)) begin
                  job_valid    = 1'b1;
                  job.kind     = hlfc_pkg::KIND_RX_BYTE;
                  job.data     = rx_byte;
                  job.position = pos9[7:0];
               end
               if (rx_byte_count_ff != 9'h1FF) begin
                  rx_byte_count_in = rx_byte_count_ff + 9'd1;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tx_in_frame_ff     <= 1'b0;
         tx_lrc_ff          <= 8'd0;
         rx_lrc_ff          <= 8'd0;
         rx_half_pending_ff <= 1'b0;
         rx_high_nibble_ff  <= 4'd0;
         rx_byte_count_ff   <= 9'd0;
         rx_first_byte_ff   <= 8'd0;
         rx_length_byte_ff  <= 8'd0;
         rx_bad_char_ff     <= 1'b0;
      end else begin
         tx_in_frame_ff     <= tx_in_frame_in;
         tx_lrc_ff          <= tx_lrc_in;
         rx_lrc_ff          <= rx_lrc_in;
         rx_half_pending_ff <= rx_half_pending_in;
         rx_high_nibble_ff  <= rx_high_nibble_in;
         rx_byte_count_ff   <= rx_byte_count_in;
         rx_first_byte_ff   <= rx_first_byte_in;
         rx_length_byte_ff  <= rx_length_byte_in;
         rx_bad_char_ff     <= rx_bad_char_in;
      end
   end

endmodule

>>> rtl/hlfc_queue.sv
// short job queue between front and back
`timescale 1ns / 1ps

module hlfc_queue #(
   parameter int DEPTH = hlfc_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  hlfc_pkg::job_type push_job,
   input  logic              pop,
   output hlfc_pkg::job_type head_job,
   output logic              empty,
   output logic              full
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   hlfc_pkg::job_type mem_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic          do_push, do_pop;

   always_comb begin
      empty    = (count_ff == CW'(0));
      full     = (count_ff == CW'(DEPTH));
      head_job = mem_ff[rd_ptr_ff];
      do_push  = push && !full;
      do_pop   = pop && !empty;

      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? PW'(0) : wr_ptr_ff + PW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? PW'(0) : rd_ptr_ff + PW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

>>> rtl/hlfc_back.sv
// back end: expands jobs into result transfers through an output register
`timescale 1ns / 1ps

module hlfc_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              lowercase_hex,
   input  hlfc_pkg::job_type head_job,
   input  logic              q_empty,
   output logic              q_pop,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output logic [1:0]        rsp_kind,
   output logic [7:0]        rsp_out_byte,
   output logic [7:0]        rsp_position,
   output logic [1:0]        rsp_status,
   output logic [7:0]        rsp_reply_len,
   output logic              rsp_run_last
);

   logic       out_valid_ff, out_valid_in;
   logic [1:0] kind_ff, kind_in;
   logic [7:0] byte_ff, byte_in;
   logic [7:0] pos_ff, pos_in;
   logic [1:0] status_ff, status_in;
   logic [7:0] rlen_ff, rlen_in;
   logic       last_ff, last_in;
   logic [3:0] step_ff, step_in;

   logic       load;
   logic [3:0] slot;
   logic [3:0] last_slot;
   logic [7:0] src;
   logic [3:0] nib;

   always_comb begin
      load      = (!out_valid_ff || rsp_pop) && !q_empty;
      slot      = (head_job.hdr ? hlfc_pkg::SLOT_HEADER : hlfc_pkg::SLOT_DATA) + step_ff;
      last_slot = head_job.eop ? hlfc_pkg::SLOT_ETX : hlfc_pkg::SLOT_DATA_LO;

      unique case (slot[2:1])
         2'd0:    src = hlfc_pkg::ACK_BYTE;
         2'd1:    src = head_job.len_byte;
         2'd2:    src = head_job.data;
         default: src = head_job.lrc;
      endcase
      nib = slot[0] ? src[3:0] : src[7:4];

      out_valid_in = out_valid_ff && !rsp_pop;
      kind_in      = kind_ff;
      byte_in      = byte_ff;
      pos_in       = pos_ff;
      status_in    = status_ff;
      rlen_in      = rlen_ff;
      last_in      = last_ff;
      step_in      = step_ff;
      q_pop        = 1'b0;

      if (load) begin
         out_valid_in = 1'b1;
         kind_in      = head_job.kind;
         pos_in       = head_job.position;
         status_in    = head_job.status;
         rlen_in      = head_job.reply_len;
         if (head_job.kind == hlfc_pkg::KIND_TX_CHAR) begin
            byte_in = (slot == hlfc_pkg::SLOT_ETX) ? hlfc_pkg::ETX_CHAR
                                                   : hlfc_pkg::hex_char(nib, lowercase_hex);
            last_in = (slot == last_slot);
         end else if (head_job.kind == hlfc_pkg::KIND_RX_BYTE) begin
            byte_in = head_job.data;
            last_in = 1'b1;
         end else begin
            byte_in = 8'd0;
            last_in = 1'b1;
         end
         if (last_in) begin
            q_pop   = 1'b1;
            step_in = 4'd0;
         end else begin
            step_in = step_ff + 4'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         step_ff      <= 4'd0;
      end else begin
         out_valid_ff <= out_valid_in;
         step_ff      <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff   <= kind_in;
      byte_ff   <= byte_in;
      pos_ff    <= pos_in;
      status_ff <= status_in;
      rlen_ff   <= rlen_in;
      last_ff   <= last_in;
   end

   assign rsp_empty     = !out_valid_ff;
   assign rsp_kind      = kind_ff;
   assign rsp_out_byte  = byte_ff;
   assign rsp_position  = pos_ff;
   assign rsp_status    = status_ff;
   assign rsp_reply_len = rlen_ff;
   assign rsp_run_last  = last_ff;

endmodule

>>> rtl/hex_ascii_lrc_frame_codec.sv
// top level of the hex ascii framer and deframer with xor lrc
`timescale 1ns / 1ps

//  channel  | direction | handshake       | payload
//  ---------+-----------+-----------------+-------------------------------------------
//  req_     | in        | push / full     | func, data_byte, msg_len, end_of_payload,
//           |           |                 | reply_limit
//  rsp_     | out       | empty / pop     | kind, out_byte, position, status,
//           |           |                 | reply_len, run_last
//  csr_     | in        | we (no wait)    | wdata = lowercase_hex
//
//  the front takes one item per cycle while the job queue has room
//  the back sequencer sends one result per cycle unless rsp_ stalls: a transmit byte
//  gives 2 to 9 results (2 plain, +4 on a frame's first, +3 on its last), a receive item 0 or 1
//  the rsp_ output register is refilled in the cycle it is popped, so transfers stream
//  synchronous reset clears frame state, the queue and the output register
//  a stalled rsp_ side fills the queue, and then full holds off further req_ transfers

module hex_ascii_lrc_frame_codec #(
   parameter int MAX_PAYLOAD = hlfc_pkg::MAX_PAYLOAD_DEFAULT,
   parameter int QUEUE_DEPTH = hlfc_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   // item input
   input  logic       req_push,
   output logic       req_full,
   input  logic       req_func,
   input  logic [7:0] req_data_byte,
   input  logic [7:0] req_msg_len,
   input  logic       req_end_of_payload,
   input  logic [7:0] req_reply_limit,
   // result output
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output logic [1:0] rsp_kind,
   output logic [7:0] rsp_out_byte,
   output logic [7:0] rsp_position,
   output logic [1:0] rsp_status,
   output logic [7:0] rsp_reply_len,
   output logic       rsp_run_last,
   // configuration
   input  logic       csr_we,
   input  logic       csr_wdata
);

   logic              lowercase_hex_ff;
   logic              accept;
   logic              job_valid;
   hlfc_pkg::job_type job;
   hlfc_pkg::job_type head_job;
   logic              q_empty;
   logic              q_full;
   logic              q_pop;

   // hex case register; the user must write it only while idle, the block does not enforce this
   always_ff @(posedge clock) begin
      if (reset) begin
         lowercase_hex_ff <= 1'b0;
      end else if (csr_we) begin
         lowercase_hex_ff <= csr_wdata;
      end
   end

   // a full queue blocks input even for items that would give no job
   assign req_full = q_full;
   assign accept   = req_push && !q_full;

   hlfc_front #(
      .MAX_PAYLOAD (MAX_PAYLOAD)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .accept         (accept),
      .func           (req_func),
      .data_byte      (req_data_byte),
      .msg_len        (req_msg_len),
      .end_of_payload (req_end_of_payload),
      .reply_limit    (req_reply_limit),
      .job_valid      (job_valid),
      .job            (job)
   );

   hlfc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (job_valid),
      .push_job (job),
      .pop      (q_pop),
      .head_job (head_job),
      .empty    (q_empty),
      .full     (q_full)
   );

   hlfc_back u_back (
      .clock         (clock),
      .reset         (reset),
      .lowercase_hex (lowercase_hex_ff),
      .head_job      (head_job),
      .q_empty       (q_empty),
      .q_pop         (q_pop),
      .rsp_empty     (rsp_empty),
      .rsp_pop       (rsp_pop),
      .rsp_kind      (rsp_kind),
      .rsp_out_byte  (rsp_out_byte),
      .rsp_position  (rsp_position),
      .rsp_status    (rsp_status),
      .rsp_reply_len (rsp_reply_len),
      .rsp_run_last  (rsp_run_last)
   );

endmodule

>>> tb/testbench.sv
// self-checking testbench for the hex ascii lrc frame codec
`timescale 1ns / 1ps

module testbench;
   import hlfc_pkg::*;

   localparam int PAYLOAD_CAP    = MAX_PAYLOAD_DEFAULT;
   localparam int SETTLE_CYCLES  = 20;     // queue depth plus sequencer, with margin
   localparam int WATCHDOG_LIMIT = 2000;   // cycles with no transfer on either side
   localparam int PHASE_ITEMS    = 24;
   localparam int DIRECTED_ROWS  = 25;

   // function select of an input item
   localparam logic FUNC_TX = 1'b0;
   localparam logic FUNC_RX = 1'b1;

   // directed rows either carry a typed-in status or rely on the predictor
   localparam logic TYPED     = 1'b1;
   localparam logic PREDICTED = 1'b0;

   // index into the idle mode flags
   localparam int SIDE_REQ = 0;
   localparam int SIDE_RSP = 1;

   typedef enum int {
      FLAW_NONE, FLAW_CHECK, FLAW_ACK, FLAW_LEN, FLAW_BADCHAR, FLAW_ODD, FLAW_NOISE
   } frame_flaw_type;

   typedef struct packed {
      logic       func;
      logic [7:0] data_byte;
      logic [7:0] msg_len;
      logic       end_of_payload;
      logic [7:0] reply_limit;
   } req_item_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] out_byte;
      logic [7:0] position;
      logic [1:0] status;
      logic [7:0] reply_len;
      logic       run_last;
   } rsp_item_type;

   typedef struct packed {
      logic       func;
      logic [7:0] data_byte;
      logic [7:0] msg_len;
      logic       eop;
      logic [7:0] reply_limit;
      logic       typed;
      logic [1:0] status;
      logic [7:0] reply_len;
   } stim_row_type;

   logic       clock;
   logic       reset;
   logic       req_push;
   logic       req_full;
   logic       req_func;
   logic [7:0] req_data_byte;
   logic [7:0] req_msg_len;
   logic       req_end_of_payload;
   logic [7:0] req_reply_limit;
   logic       rsp_empty;
   logic       rsp_pop;
   logic [1:0] rsp_kind;
   logic [7:0] rsp_out_byte;
   logic [7:0] rsp_position;
   logic [1:0] rsp_status;
   logic [7:0] rsp_reply_len;
   logic       rsp_run_last;
   logic       csr_we;
   logic       csr_wdata;

   hex_ascii_lrc_frame_codec #(
      .MAX_PAYLOAD (PAYLOAD_CAP)
   ) u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_push           (req_push),
      .req_full           (req_full),
      .req_func           (req_func),
      .req_data_byte      (req_data_byte),
      .req_msg_len        (req_msg_len),
      .req_end_of_payload (req_end_of_payload),
      .req_reply_limit    (req_reply_limit),
      .rsp_empty          (rsp_empty),
      .rsp_pop            (rsp_pop),
      .rsp_kind           (rsp_kind),
      .rsp_out_byte       (rsp_out_byte),
      .rsp_position       (rsp_position),
      .rsp_status         (rsp_status),
      .rsp_reply_len      (rsp_reply_len),
      .rsp_run_last       (rsp_run_last),
      .csr_we             (csr_we),
      .csr_wdata          (csr_wdata)
   );

   always #5 clock = ~clock;

   // directed part: extremes, every status but checksum, both hex cases on receive
   stim_row_type stim_table [DIRECTED_ROWS] = '{
      // transmit: opening byte with length zero, then a close with length ignored
      {FUNC_TX, 8'h00, 8'h00, 1'b0, 8'h00, PREDICTED, STATUS_OK, 8'h00},
      {FUNC_TX, 8'hFF, 8'hFF, 1'b1, 8'hFF, PREDICTED, STATUS_OK, 8'h00},
      // transmit: single byte frame, open and close on one transfer
      {FUNC_TX, 8'hA5, 8'hFF, 1'b1, 8'h5A, PREDICTED, STATUS_OK, 8'h00},
      // receive: end mark with nothing before it
      {FUNC_RX, ETX_CHAR, 8'h00, 1'b0, 8'h00, TYPED, STATUS_PROTOCOL, 8'h00},
      // receive: odd character count
      {FUNC_RX, "7", 8'h00, 1'b0, 8'h00, PREDICTED, STATUS_OK, 8'h00},
      {FUNC_RX, ETX_CHAR, 8'h00, 1'b0, 8'h00, TYPED, STATUS_PROTOCOL, 8'h00},
      // receive: two non-hex characters at the byte extremes
      {FUNC_RX, 8'hFF, 8'hFF, 1'b1, 8'hFF, PREDICTED, STATUS_OK, 8'h00},
      {FUNC_RX, 8'h00, 8'h00, 1'b0, 8'hFF, PREDICTED, STATUS_OK, 8'h00},
      {FUNC_RX, ETX_CHAR, 8'h00, 1'b0, 8'hFF, TYPED, STATUS_PROTOCOL, 8'h00},
      // receive: good frame 60 01 AB CA in mixed case, one payload byte
      {FUNC_RX, "6", 8'h00, 1'b0, 8'hFF, PREDICTED, STATUS_OK, 8'h00},
      {FUNC_RX, "0", 8'h00, 1'b0, 8'hFF, PREDICTED, STATUS_OK, 8'h00},
      {FUNC_RX, "0", 8'h00, 1'b0, 8'hFF, PREDICTED, STATUS_OK, 8'h00},
      {FUNC_RX, "1", 8'h00, 1'b0, 8'hFF, PREDICTED, STATUS_OK, 8'h00},
      {FUNC_RX, "a", 8'h00, 1'b0, 8'hFF, PREDICTED, STATUS_OK, 8'h00},
      {FUNC_RX, "B", 8'h00, 1'b0, 8'hFF, PREDICTED, STATUS_OK, 8'h00},
      {FUNC_RX, "c", 8'h00, 1'b0, 8'hFF, PREDICTED, STATUS_OK, 8'h00},
      {FUNC_RX, "A", 8'h00, 1'b0, 8'hFF, PREDICTED, STATUS_OK, 8'h00},
      {FUNC_RX, ETX_CHAR, 8'h00, 1'b0, 8'hFF, TYPED, STATUS_OK, 8'h01},
      // receive: 00 00 00, clean checksum but no ack byte, reply limit zero
      {FUNC_RX, "0", 8'h00, 1'b0, 8'h00, PREDICTED, STATUS_OK, 8'h00},
      {FUNC_RX, "0", 8'h00, 1'b0, 8'h00, PREDICTED, STATUS_OK, 8'h00},
      {FUNC_RX, "0", 8'h00, 1'b0, 8'h00, PREDICTED, STATUS_OK, 8'h00},
      {FUNC_RX, "0", 8'h00, 1'b0, 8'h00, PREDICTED, STATUS_OK, 8'h00},
      {FUNC_RX, "0", 8'h00, 1'b0, 8'h00, PREDICTED, STATUS_OK, 8'h00},
      {FUNC_RX, "0", 8'h00, 1'b0, 8'h00, PREDICTED, STATUS_OK, 8'h00},
      {FUNC_RX, ETX_CHAR, 8'h00, 1'b0, 8'h00, TYPED, STATUS_NO_ACK, 8'h00}
   };

   // predictor state, mirrors the block after each accepted transfer
   logic       cfg_lower;
   logic       tx_open;
   logic [7:0] tx_sum;
   logic [7:0] rx_sum;
   logic       rx_half;
   logic [3:0] rx_hi;
   logic [8:0] rx_count;
   logic [7:0] rx_ack;
   logic [7:0] rx_len;
   logic       rx_bad;

   rsp_item_type step_outputs[$];       // results of the item being predicted
   rsp_item_type codec_outputs_due[$];  // results still to come out, oldest first
   req_item_type tx_feed[$];
   req_item_type rx_feed[$];

   bit burst_mode [2];
   int next_tx_gap;
   int items_sent;
   int fail_count;
   int quiet_cycles;
   rsp_item_type head_due;

   // idle cycles before the next transfer; runs of zero gaps now and then
   function automatic int draw_gap(input int side);
      if ($urandom_range(0, 19) == 0) burst_mode[side] = !burst_mode[side];
      return burst_mode[side] ? 0 : $urandom_range(0, 19);
   endfunction

   function automatic logic [7:0] glyph(input logic [3:0] v, input logic lower);
      if (v < 4'd10) return "0" + {4'h0, v};
      return (lower ? "a" : "A") + {4'h0, v} - 8'd10;
   endfunction

   // {valid, nibble}, nibble zero when the character is not hex
   function automatic logic [4:0] decode_hex(input logic [7:0] c);
      logic [7:0] d;
      d = 8'h00;
      if (c >= "0" && c <= "9") begin
         d = c - "0";
      end else if (c >= "A" && c <= "F") begin
         d = c - "A" + 8'd10;
      end else if (c >= "a" && c <= "f") begin
         d = c - "a" + 8'd10;
      end else begin
         return 5'b0;
      end
      return {1'b1, d[3:0]};
   endfunction

   function automatic void emit(input logic [1:0] kind, input logic [7:0] ob,
                                input logic [7:0] pos, input logic [1:0] st,
                                input logic [7:0] rl);
      rsp_item_type r;
      r = {kind, ob, pos, st, rl, 1'b0};
      step_outputs.push_back(r);
   endfunction

   function automatic void emit_hex(input logic [7:0] b);
      emit(KIND_TX_CHAR, glyph(b[7:4], cfg_lower), 8'h00, STATUS_OK, 8'h00);
      emit(KIND_TX_CHAR, glyph(b[3:0], cfg_lower), 8'h00, STATUS_OK, 8'h00);
   endfunction

   function automatic void clear_rx_frame();
      rx_sum   = 8'h00;
      rx_half  = 1'b0;
      rx_hi    = 4'h0;
      rx_count = 9'd0;
      rx_ack   = 8'h00;
      rx_len   = 8'h00;
      rx_bad   = 1'b0;
   endfunction

   // works out the results of one accepted item into step_outputs
   function automatic void predict_codec_outputs(input req_item_type it);
      logic [4:0]   dec;
      logic [7:0]   b;
      logic [1:0]   st;
      int           cnt, rl, pos;
      rsp_item_type tail;
      step_outputs.delete();
      cnt = int'(rx_count);
      if (it.func == FUNC_TX) begin
         // a new frame leads with the ack byte and the length byte
         if (!tx_open) begin
            emit_hex(ACK_BYTE);
            emit_hex(it.msg_len);
            tx_sum  = ACK_BYTE ^ it.msg_len;
            tx_open = 1'b1;
         end
         emit_hex(it.data_byte);
         tx_sum = tx_sum ^ it.data_byte;
         if (it.end_of_payload) begin
            emit_hex(tx_sum);
            emit(KIND_TX_CHAR, ETX_CHAR, 8'h00, STATUS_OK, 8'h00);
            tx_open = 1'b0;
            tx_sum  = 8'h00;
         end
      end else if (it.data_byte == ETX_CHAR) begin
         // status priority: framing, short, checksum, ack, length
         st = STATUS_OK;
         rl = 0;
         if (rx_half || rx_bad) st = STATUS_PROTOCOL;
         else if (cnt < 3) st = STATUS_PROTOCOL;
         else if (rx_sum != 8'h00) st = STATUS_CHECKSUM;
         else if (rx_ack != ACK_BYTE) st = STATUS_NO_ACK;
         else if (cnt - 3 != int'(rx_len)) st = STATUS_PROTOCOL;
         else begin
            rl = cnt - 3;
            if (rl > int'(it.reply_limit)) rl = int'(it.reply_limit);
            if (rl > PAYLOAD_CAP) rl = PAYLOAD_CAP;
         end
         emit(KIND_RX_STATUS, 8'h00, 8'h00, st, rl[7:0]);
         clear_rx_frame();
      end else begin
         dec = decode_hex(it.data_byte);
         if (!dec[4]) rx_bad = 1'b1;
         if (!rx_half) begin
            rx_hi   = dec[3:0];
            rx_half = 1'b1;
         end else begin
            b       = {rx_hi, dec[3:0]};
            rx_half = 1'b0;
            rx_hi   = 4'h0;
            rx_sum  = rx_sum ^ b;
            if (cnt == 0) begin
               rx_ack = b;
            end else if (cnt == 1) begin
               rx_len = b;
            end else begin
               // tentative payload, the checksum byte included
               pos = cnt - 2;
               if (pos < int'(it.reply_limit) && pos < PAYLOAD_CAP)
                  emit(KIND_RX_BYTE, b, pos[7:0], STATUS_OK, 8'h00);
            end
            if (rx_count < 9'd511) rx_count = rx_count + 9'd1;
         end
      end
      if (step_outputs.size() > 0) begin
         tail = step_outputs.pop_back();
         tail.run_last = 1'b1;
         step_outputs.push_back(tail);
      end
   endfunction

   // one transfer on the req_ side; push stays high when the next gap is zero
   task automatic send_item(input req_item_type it, input logic typed,
                            input logic [1:0] st, input logic [7:0] rl);
      rsp_item_type fixed;
      repeat (next_tx_gap) @(negedge clock);
      req_func           <= it.func;
      req_data_byte      <= it.data_byte;
      req_msg_len        <= it.msg_len;
      req_end_of_payload <= it.end_of_payload;
      req_reply_limit    <= it.reply_limit;
      req_push           <= 1'b1;
      do @(posedge clock); while (req_full);
      @(negedge clock);
      next_tx_gap = draw_gap(SIDE_REQ);
      if (next_tx_gap > 0) req_push <= 1'b0;
      predict_codec_outputs(it);
      if (typed) begin
         // status read off by hand; predictor state still moves on
         fixed = {KIND_RX_STATUS, 8'h00, 8'h00, st, rl, 1'b1};
         codec_outputs_due.push_back(fixed);
      end else begin
         foreach (step_outputs[i]) codec_outputs_due.push_back(step_outputs[i]);
      end
   endtask

   // sender holds off until every due result has come out
   task automatic drain_results(input int settle);
      if (next_tx_gap == 0) begin
         req_push    <= 1'b0;
         next_tx_gap = 1;
      end
      while (codec_outputs_due.size() != 0) @(negedge clock);
      repeat (settle) @(negedge clock);
   endtask

   task automatic write_case_select(input logic lower);
      csr_wdata <= lower;
      csr_we    <= 1'b1;
      @(negedge clock);
      csr_we    <= 1'b0;
      cfg_lower = lower;
   endtask

   task automatic queue_tx_frame(input int nbytes);
      req_item_type it;
      logic [7:0]   len;
      len = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255)) : 8'(nbytes);
      for (int i = 0; i < nbytes; i++) begin
         it.func           = FUNC_TX;
         it.data_byte      = 8'($urandom_range(0, 255));
         it.msg_len        = (i == 0) ? len : 8'($urandom_range(0, 255));
         // now and then a frame is left open and runs into the next one
         it.end_of_payload = (i == nbytes - 1) && ($urandom_range(0, 7) != 0);
         it.reply_limit    = 8'($urandom_range(0, 255));
         tx_feed.push_back(it);
      end
   endtask

   // builds a receive frame as hex characters plus end mark, flawed on request
   task automatic queue_rx_frame(input int npay, input logic [7:0] limit,
                                 input frame_flaw_type flaw);
      logic [7:0]   frame_bytes[$];
      logic [7:0]   chars[$];
      logic [7:0]   sum, c;
      int           at;
      req_item_type it;
      frame_bytes.push_back(ACK_BYTE);
      frame_bytes.push_back(npay[7:0]);
      for (int i = 0; i < npay; i++) frame_bytes.push_back(8'($urandom_range(0, 255)));
      if (flaw == FLAW_ACK) frame_bytes[0] = ACK_BYTE ^ 8'($urandom_range(1, 255));
      if (flaw == FLAW_LEN) frame_bytes[1] = npay[7:0] + 8'($urandom_range(1, 255));
      sum = 8'h00;
      foreach (frame_bytes[i]) sum = sum ^ frame_bytes[i];
      if (flaw == FLAW_CHECK) sum = sum ^ (8'h01 << $urandom_range(0, 7));
      frame_bytes.push_back(sum);
      foreach (frame_bytes[i]) begin
         chars.push_back(glyph(frame_bytes[i][7:4], 1'($urandom_range(0, 1))));
         chars.push_back(glyph(frame_bytes[i][3:0], 1'($urandom_range(0, 1))));
      end
      at = $urandom_range(0, chars.size() - 1);
      if (flaw == FLAW_BADCHAR) begin
         do c = 8'($urandom_range(0, 255)); while (decode_hex(c) != 5'b0 || c == ETX_CHAR);
         chars[at] = c;
      end else if (flaw == FLAW_ODD) begin
         chars.delete(at);
      end else if (flaw == FLAW_NOISE) begin
         // line garbage, may hold an early end mark
         chars.delete();
         repeat ($urandom_range(1, 8)) chars.push_back(8'($urandom_range(0, 255)));
      end
      chars.push_back(ETX_CHAR);
      foreach (chars[i]) begin
         it.func           = FUNC_RX;
         it.data_byte      = chars[i];
         it.msg_len        = 8'($urandom_range(0, 255));
         it.end_of_payload = 1'($urandom_range(0, 1));
         it.reply_limit    = (i != chars.size() - 1 && $urandom_range(0, 15) == 0) ?
                             8'($urandom_range(0, 255)) : limit;
         rx_feed.push_back(it);
      end
   endtask

   // interleaves the two feeds at random, both sides are independent
   task automatic play_feeds();
      req_item_type it;
      bit           from_tx;
      while (tx_feed.size() + rx_feed.size() > 0) begin
         if (rx_feed.size() == 0) from_tx = 1'b1;
         else if (tx_feed.size() == 0) from_tx = 1'b0;
         else from_tx = 1'($urandom_range(0, 1));
         it = from_tx ? tx_feed.pop_front() : rx_feed.pop_front();
         if ($urandom_range(0, 39) == 0) drain_results(0);
         send_item(it, 1'b0, STATUS_OK, 8'h00);
         items_sent++;
      end
   endtask

   // rsp_ side: sampled at the rising edge, compared field by field
   function automatic void check_field(input string name, input logic [7:0] want,
                                       input logic [7:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %0h, got %0h", name, want, got);
         fail_count++;
      end
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_pop && !rsp_empty) begin
         if (codec_outputs_due.size() == 0) begin
            $error("result transfer with nothing expected: kind %0d byte %0h",
                   rsp_kind, rsp_out_byte);
            fail_count++;
         end else begin
            head_due = codec_outputs_due.pop_front();
            check_field("kind", head_due.kind, rsp_kind);
            check_field("out_byte", head_due.out_byte, rsp_out_byte);
            check_field("position", head_due.position, rsp_position);
            check_field("status", head_due.status, rsp_status);
            check_field("reply_len", head_due.reply_len, rsp_reply_len);
            check_field("run_last", head_due.run_last, rsp_run_last);
         end
      end
   end

   // watchdog: any transfer on either side resets the count
   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
         end
      end
   end

   // rsp_ side pop with random gaps; pop stays high across zero gaps
   initial begin
      int gap;
      rsp_pop = 1'b0;
      gap = 1;
      wait (!reset);
      @(negedge clock);
      forever begin
         if (gap > 0) begin
            rsp_pop <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_pop <= 1'b1;
         do @(posedge clock); while (rsp_empty);
         @(negedge clock);
         gap = draw_gap(SIDE_RSP);
      end
   end

   initial begin
      int           npay;
      logic [7:0]   limit;
      int           r;
      req_item_type it;
      clock              = 1'b0;
      reset              = 1'b1;
      req_push           = 1'b0;
      req_func           = FUNC_TX;
      req_data_byte      = 8'h00;
      req_msg_len        = 8'h00;
      req_end_of_payload = 1'b0;
      req_reply_limit    = 8'h00;
      csr_we             = 1'b0;
      csr_wdata          = 1'b0;
      fail_count         = 0;
      quiet_cycles       = 0;
      next_tx_gap        = 1;
      cfg_lower          = 1'b0;
      tx_open            = 1'b0;
      tx_sum             = 8'h00;
      clear_rx_frame();
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      write_case_select(1'b0);

      // directed table
      foreach (stim_table[i]) begin
         it = {stim_table[i].func, stim_table[i].data_byte, stim_table[i].msg_len,
               stim_table[i].eop, stim_table[i].reply_limit};
         send_item(it, stim_table[i].typed, stim_table[i].status, stim_table[i].reply_len);
      end

      // random phases, hex case flipped between them while idle
      for (int phase = 0; phase < 3; phase++) begin
         drain_results(SETTLE_CYCLES);
         write_case_select(phase != 1);
         items_sent = 0;
         while (items_sent < PHASE_ITEMS) begin
            if ($urandom_range(0, 2) != 0) queue_tx_frame($urandom_range(1, 5));
            npay = $urandom_range(0, 6);
            r    = $urandom_range(0, 3);
            if (r == 0) limit = 8'($urandom_range(0, npay + 1));
            else if (r == 1) limit = 8'hFF;
            else limit = 8'($urandom_range(0, 255));
            r = $urandom_range(0, 11);
            queue_rx_frame(npay, limit, (r < 6) ? FLAW_NONE : frame_flaw_type'(r - 5));
            play_feeds();
         end
      end

      drain_results(SETTLE_CYCLES);
      if (fail_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

>>> sim.f
rtl/hlfc_pkg.sv
rtl/hlfc_front.sv
rtl/hlfc_queue.sv
rtl/hlfc_back.sv
rtl/hex_ascii_lrc_frame_codec.sv
tb/testbench.sv
